FILE: sv/faot_pkg.sv
// ----------------------------------------------------------------------------
// faot_pkg
// Shared types and constants of the frustum/box separating-axis tester.
// ----------------------------------------------------------------------------
package faot_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Transaction modes
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_BOX  = 1'b1;

  // Frustum word map
  localparam int WI_ORG    = 0;
  localparam int WI_DIR    = 3;
  localparam int WI_UP     = 6;
  localparam int WI_RIGHT  = 9;
  localparam int WI_RBOUND = 12;
  localparam int WI_UBOUND = 13;
  localparam int WI_DMIN   = 14;
  localparam int WI_RATIO  = 15;
  localparam int WI_PLANE  = 16;

  localparam int NUM_AX       = 8;
  localparam int NUM_BASIC_AX = 3;
  localparam int NUM_CHUNKS   = 3;

  // Dot phase ops (one per component)
  localparam logic [2:0] OP_CP  = 3'd0;
  localparam logic [2:0] OP_BR  = 3'd1;
  localparam logic [2:0] OP_DU  = 3'd2;
  localparam logic [2:0] OP_DR  = 3'd3;
  localparam logic [2:0] OP_DD  = 3'd4;
  // Frustum phase ops
  localparam logic [2:0] OP_FRU = 3'd0;
  localparam logic [2:0] OP_FRR = 3'd1;
  localparam logic [2:0] OP_FC  = 3'd2;
  localparam logic [2:0] OP_LO  = 3'd3;
  localparam logic [2:0] OP_HI  = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_AXLD,
    S_NRD,
    S_ISSUE,
    S_MACC,
    S_WB,
    S_LOHI,
    S_CMP
  } st_e;

  typedef enum logic {
    PH_DOT,
    PH_FRUST
  } ph_e;

endpackage

FILE: sv/frustum_aabb_overlap_test.sv
// ----------------------------------------------------------------------------
// frustum_aabb_overlap_test
// Frustum versus axis-aligned box culling by separating axes.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken when start_i is high and busy_o is low.
// mode_i = 0 writes param_value_i into frustum word param_index_i and gives
// no result. mode_i = 1 tests the box min/max corners against the stored
// frustum and gives one result: done_o pulses for one cycle with overlaps_o
// (1 = overlap, 0 = culled). The receiver cannot stall; sample done_o every
// cycle. A box test walks the x, y, z axes and then the far, bottom, up,
// left and right normals, and stops at the first separating axis. All
// products run on one shared multiplier that takes a wide operand in three
// chunks per product (issue, accumulate per chunk, then write back). The
// frustum store is cleared by reset.
// ----------------------------------------------------------------------------
module frustum_aabb_overlap_test
  import faot_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               mode_i,
  input  logic [4:0]         param_index_i,
  input  logic signed [31:0] param_value_i,
  input  logic signed [31:0] min_x_i,
  input  logic signed [31:0] min_y_i,
  input  logic signed [31:0] min_z_i,
  input  logic signed [31:0] max_x_i,
  input  logic signed [31:0] max_y_i,
  input  logic signed [31:0] max_z_i,
  output logic               done_o,
  output logic               overlaps_o
);

  // Width of the wide_t intermediates (ratio-scaled bound is the widest value).
  localparam int WW  = 134 - 3 * FRAC_BITS;
  // Widest multiplier operand (frustum bound before ratio scaling).
  localparam int AW  = 100 - 2 * FRAC_BITS;
  localparam int CH  = (AW + NUM_CHUNKS - 1) / NUM_CHUNKS;
  localparam int AWP = CH * NUM_CHUNKS;
  localparam int PW  = AWP + 32;

  typedef logic signed [WW-1:0] wide_t;

  function automatic wide_t sx(input logic [31:0] w);
    return WW'(signed'(w));
  endfunction

  // Frustum store
  logic [31:0] mem_q [32];

  // Control
  st_e        st_q, st_d;
  ph_e        ph_q, ph_d;
  logic [2:0] ax_q, ax_d;
  logic [1:0] i_q, i_d;
  logic [2:0] op_q, op_d;
  logic [1:0] ch_q;
  logic       done_q, ovl_q;

  // Datapath
  wide_t rc_q [3];
  wide_t hs_q [3];
  wide_t cp_q, br_q, du_q, dr_q, dd_q, fr_q, fc_q, lo_q, hi_q;
  logic signed [31:0]   n_q;
  logic signed [AWP-1:0] ma_q;
  logic signed [31:0]   mb_q;
  logic signed [PW-1:0] macc_q;

  logic [4:0]  rd_addr;
  logic [31:0] rd_word;
  wide_t       op_a;
  logic        use_n;
  logic        fin;
  logic        sep;
  logic        accept;

  assign busy_o  = (st_q != S_IDLE);
  assign accept  = start_i && !busy_o;
  assign rd_word = mem_q[rd_addr];

  // Shared multiplier: one chunk of A (signed only for the top chunk) times B per cycle
  logic [AWP-1:0]       a_sh;
  logic [CH-1:0]        chunk;
  logic signed [CH:0]   chunk_ext;
  logic signed [CH+32:0] prod;
  logic signed [PW-1:0] addend;
  wide_t                mres;

  assign a_sh      = ma_q >> (CH * ch_q);
  assign chunk     = a_sh[CH-1:0];
  assign chunk_ext = (ch_q == 2'(NUM_CHUNKS - 1)) ? {chunk[CH-1], chunk} : {1'b0, chunk};
  assign prod      = chunk_ext * mb_q;
  assign addend    = PW'(prod) <<< (CH * ch_q);
  assign mres      = WW'(macc_q >>> FRAC_BITS);

  // Separation test on the current axis
  wide_t cpb, cmb;
  assign cpb = cp_q + br_q;
  assign cmb = cp_q - br_q;
  assign sep = (cpb < lo_q) || (hi_q < cmb);

  // Box centre and half size
  logic signed [32:0] sum_x, sum_y, sum_z, dif_x, dif_y, dif_z;
  assign sum_x = 33'(max_x_i) + 33'(min_x_i);
  assign sum_y = 33'(max_y_i) + 33'(min_y_i);
  assign sum_z = 33'(max_z_i) + 33'(min_z_i);
  assign dif_x = 33'(max_x_i) - 33'(min_x_i);
  assign dif_y = 33'(max_y_i) - 33'(min_y_i);
  assign dif_z = 33'(max_z_i) - 33'(min_z_i);

  // Sequencer
  always_comb begin
    st_d    = st_q;
    ph_d    = ph_q;
    ax_d    = ax_q;
    i_d     = i_q;
    op_d    = op_q;
    rd_addr = '0;
    op_a    = '0;
    use_n   = 1'b0;
    fin     = 1'b0;
    case (st_q)
      S_IDLE: begin
        if (accept && (mode_i == MODE_BOX)) begin
          st_d = S_PREP;
          i_d  = '0;
        end
      end
      S_PREP: begin
        rd_addr = 5'(WI_ORG + int'(i_q));
        if (i_q == 2'd2) begin
          st_d = S_AXLD;
          i_d  = '0;
          ax_d = '0;
        end else begin
          i_d = i_q + 2'd1;
        end
      end
      S_AXLD: begin
        if (ax_q < 3'(NUM_BASIC_AX)) begin
          case (i_q)
            2'd0:    rd_addr = 5'(WI_UP + int'(ax_q));
            2'd1:    rd_addr = 5'(WI_RIGHT + int'(ax_q));
            default: rd_addr = 5'(WI_DIR + int'(ax_q));
          endcase
          if (i_q == 2'd2) begin
            st_d = S_ISSUE;
            ph_d = PH_FRUST;
            op_d = OP_FRU;
            i_d  = '0;
          end else begin
            i_d = i_q + 2'd1;
          end
        end else begin
          st_d = S_NRD;
          i_d  = '0;
        end
      end
      S_NRD: begin
        rd_addr = 5'(WI_PLANE + 3 * (int'(ax_q) - NUM_BASIC_AX) + int'(i_q));
        st_d    = S_ISSUE;
        ph_d    = PH_DOT;
        op_d    = OP_CP;
      end
      S_ISSUE: begin
        st_d = S_MACC;
        if (ph_q == PH_DOT) begin
          case (op_q)
            OP_CP: begin
              op_a  = rc_q[i_q];
              use_n = 1'b1;
            end
            OP_BR: begin
              // |n| * h taken as (sign(n) * h) * n
              op_a  = n_q[31] ? -hs_q[i_q] : hs_q[i_q];
              use_n = 1'b1;
            end
            OP_DU: begin
              op_a    = sx(n_q);
              rd_addr = 5'(WI_UP + int'(i_q));
            end
            OP_DR: begin
              op_a    = sx(n_q);
              rd_addr = 5'(WI_RIGHT + int'(i_q));
            end
            default: begin
              op_a    = sx(n_q);
              rd_addr = 5'(WI_DIR + int'(i_q));
            end
          endcase
        end else begin
          case (op_q)
            OP_FRU: begin
              op_a    = du_q[WW-1] ? -du_q : du_q;
              rd_addr = 5'(WI_UBOUND);
            end
            OP_FRR: begin
              op_a    = dr_q[WW-1] ? -dr_q : dr_q;
              rd_addr = 5'(WI_RBOUND);
            end
            OP_FC: begin
              op_a    = dd_q;
              rd_addr = 5'(WI_DMIN);
            end
            OP_LO: begin
              op_a    = lo_q;
              rd_addr = 5'(WI_RATIO);
              if (!lo_q[WW-1]) begin
                st_d = S_ISSUE;
                op_d = OP_HI;
              end
            end
            default: begin
              op_a    = hi_q;
              rd_addr = 5'(WI_RATIO);
              if (!hi_q[WW-1]) st_d = S_CMP;
            end
          endcase
        end
      end
      S_MACC: begin
        if (ch_q == 2'(NUM_CHUNKS - 1)) st_d = S_WB;
      end
      S_WB: begin
        if (ph_q == PH_DOT) begin
          if (op_q != OP_DD) begin
            op_d = op_q + 3'd1;
            st_d = S_ISSUE;
          end else if (i_q != 2'd2) begin
            i_d  = i_q + 2'd1;
            st_d = S_NRD;
          end else begin
            ph_d = PH_FRUST;
            op_d = OP_FRU;
            st_d = S_ISSUE;
          end
        end else begin
          case (op_q)
            OP_FRU, OP_FRR: begin
              op_d = op_q + 3'd1;
              st_d = S_ISSUE;
            end
            OP_FC:   st_d = S_LOHI;
            OP_LO: begin
              op_d = OP_HI;
              st_d = S_ISSUE;
            end
            default: st_d = S_CMP;
          endcase
        end
      end
      S_LOHI: begin
        st_d = S_ISSUE;
        op_d = OP_LO;
      end
      S_CMP: begin
        if (sep || ax_q == 3'(NUM_AX - 1)) begin
          st_d = S_IDLE;
          fin  = 1'b1;
        end else begin
          ax_d = ax_q + 3'd1;
          i_d  = '0;
          st_d = S_AXLD;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  // Control registers and frustum store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ph_q   <= PH_DOT;
      ax_q   <= '0;
      i_q    <= '0;
      op_q   <= '0;
      ch_q   <= '0;
      done_q <= 1'b0;
      ovl_q  <= 1'b0;
      for (int j = 0; j < 32; j++) mem_q[j] <= '0;
    end else begin
      st_q   <= st_d;
      ph_q   <= ph_d;
      ax_q   <= ax_d;
      i_q    <= i_d;
      op_q   <= op_d;
      done_q <= fin;
      if (fin) ovl_q <= !sep;
      if (st_q == S_ISSUE) ch_q <= '0;
      else if (st_q == S_MACC) ch_q <= ch_q + 2'd1;
      if (accept && (mode_i == MODE_LOAD)) mem_q[param_index_i] <= param_value_i;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_IDLE: begin
        if (accept && (mode_i == MODE_BOX)) begin
          rc_q[0] <= WW'(sum_x >>> 1);
          rc_q[1] <= WW'(sum_y >>> 1);
          rc_q[2] <= WW'(sum_z >>> 1);
          hs_q[0] <= WW'(dif_x >>> 1);
          hs_q[1] <= WW'(dif_y >>> 1);
          hs_q[2] <= WW'(dif_z >>> 1);
        end
      end
      S_PREP: rc_q[i_q] <= rc_q[i_q] - sx(rd_word);
      S_AXLD: begin
        if (ax_q < 3'(NUM_BASIC_AX)) begin
          case (i_q)
            2'd0: begin
              cp_q <= rc_q[ax_q[1:0]];
              br_q <= hs_q[ax_q[1:0]];
              du_q <= sx(rd_word);
            end
            2'd1:    dr_q <= sx(rd_word);
            default: dd_q <= sx(rd_word);
          endcase
        end else begin
          cp_q <= '0;
          br_q <= '0;
          du_q <= '0;
          dr_q <= '0;
          dd_q <= '0;
        end
      end
      S_NRD: n_q <= signed'(rd_word);
      S_ISSUE: begin
        ma_q   <= op_a[AWP-1:0];
        mb_q   <= use_n ? n_q : signed'(rd_word);
        macc_q <= '0;
      end
      S_MACC: macc_q <= macc_q + addend;
      S_WB: begin
        if (ph_q == PH_DOT) begin
          case (op_q)
            OP_CP:   cp_q <= cp_q + mres;
            OP_BR:   br_q <= br_q + mres;
            OP_DU:   du_q <= du_q + mres;
            OP_DR:   dr_q <= dr_q + mres;
            default: dd_q <= dd_q + mres;
          endcase
        end else begin
          case (op_q)
            OP_FRU:  fr_q <= mres;
            OP_FRR:  fr_q <= fr_q + mres;
            OP_FC:   fc_q <= mres;
            OP_LO:   lo_q <= mres;
            default: hi_q <= mres;
          endcase
        end
      end
      S_LOHI: begin
        lo_q <= fc_q - fr_q;
        hi_q <= fc_q + fr_q;
      end
      default: ;
    endcase
  end

  assign done_o     = done_q;
  assign overlaps_o = ovl_q;

endmodule

FILE: sv/faot_checker.sv
// ----------------------------------------------------------------------------
// faot_props
// Port-level checks of the frustum/box tester, bound to the top level.
// ----------------------------------------------------------------------------
module faot_props (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic mode_i,
  input logic done_o
);

  // result only at the end of a busy stretch
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o && $past(busy_o))
    else $error("result outside of a box test");

  // a box transaction starts a busy stretch
  a_box_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i) |=> busy_o)
    else $error("box transaction not started");

  // a load transaction neither blocks nor gives a result
  a_load_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !mode_i) |=> !busy_o && !done_o)
    else $error("load transaction misbehaved");

  // busy only ever begins with a box transaction
  a_busy_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && mode_i))
    else $error("busy without box transaction");

endmodule

bind frustum_aabb_overlap_test faot_props u_faot_props (.*);
